FILE: sv/gne_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gne_pkg
// Shared widths, constants, types and neighbour stepping functions for the
// grid neighbour expander.
// ----------------------------------------------------------------------------
package gne_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int NB         = 8;
	localparam int NB_W       = $clog2(NB);
	localparam int COST_W     = FRAC_BITS + 1;
	localparam int EST_W      = COORD_BITS + 1 + FRAC_BITS;

	localparam longint unsigned SQRT2_Q32 = 64'd6074000990;
	localparam longint unsigned SQRT2_QL  =
		(SQRT2_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
	localparam logic [COST_W-1:0] COST_STRAIGHT = COST_W'(64'd1 << FRAC_BITS);
	localparam logic [COST_W-1:0] COST_DIAG     = COST_W'(SQRT2_QL);

	localparam int IN_BITS  = 4 * COORD_BITS + NB;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 2 * COORD_BITS + COST_W + EST_W + 1;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int REG_IDX_W = 2;
	localparam int CFG_W     = COORD_BITS;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_HEURISTIC_MODE = 2'd0,
		REG_GOAL_X         = 2'd1,
		REG_GOAL_Y         = 2'd2
	} reg_idx_t;

	localparam logic MODE_MANHATTAN = 1'b0;
	localparam logic MODE_OCTILE    = 1'b1;

	// neighbour order: left, up, right, down, then the diagonals
	localparam logic [NB_W-1:0] NB_LEFT  = NB_W'(0);
	localparam logic [NB_W-1:0] NB_UP    = NB_W'(1);
	localparam logic [NB_W-1:0] NB_RIGHT = NB_W'(2);
	localparam logic [NB_W-1:0] NB_DOWN  = NB_W'(3);
	localparam logic [NB_W-1:0] NB_PP    = NB_W'(4);
	localparam logic [NB_W-1:0] NB_PM    = NB_W'(5);
	localparam logic [NB_W-1:0] NB_MP    = NB_W'(6);
	localparam logic [NB_W-1:0] NB_MM    = NB_W'(7);

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t        x;
		coord_t        y;
		logic [NB-1:0] mask;
	} node_t;

	typedef struct packed {
		logic   mode;
		coord_t goal_x;
		coord_t goal_y;
	} cfg_t;

	function automatic coord_t step_x(coord_t c, logic [NB_W-1:0] idx);
		coord_t r;
		r = c;
		if (idx inside {NB_RIGHT, NB_PP, NB_PM})
			r = c + coord_t'(1);
		else if (idx inside {NB_LEFT, NB_MP, NB_MM})
			r = c - coord_t'(1);
		return r;
	endfunction

	function automatic coord_t step_y(coord_t c, logic [NB_W-1:0] idx);
		coord_t r;
		r = c;
		if (idx inside {NB_DOWN, NB_PP, NB_MP})
			r = c + coord_t'(1);
		else if (idx inside {NB_UP, NB_PM, NB_MM})
			r = c - coord_t'(1);
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: sv/grid_neighbour_expander.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_neighbour_expander
// Expands one grid node into its legal, non-parent neighbours with step
// cost, goal distance estimate and goal hit flag.
// ----------------------------------------------------------------------------
// A node transaction is taken every cycle while the four-entry node queue
// has room; the generator then emits one successor per cycle unless the
// output stalls, so the queue fills when nodes with many successors (up to
// eight) arrive faster than that. Each successor passes the node register
// and stages s1 to s4; the last one of a node carries tlast, and a node with
// no successor yields nothing. Write the heuristic mode and goal registers
// only while no successor is outstanding.
module grid_neighbour_expander
	import gne_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// node_x, node_y, pred_x, pred_y, legal_mask
	input  wire logic [IN_W-1:0]      s_tdata,
	// parent_valid
	input  wire logic                 s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// succ_x, succ_y, step_cost, goal_estimate, reaches_goal, zero pad
	output logic [OUT_W-1:0]          m_tdata,
	output logic                      m_tlast
);

	cfg_t  cfg_q;
	logic  fq_valid, fq_ready, bq_valid, bq_ready;
	node_t fq_data, bq_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEURISTIC_MODE: cfg_q.mode   <= cfg_data[0];
				REG_GOAL_X:         cfg_q.goal_x <= coord_t'(cfg_data);
				REG_GOAL_Y:         cfg_q.goal_y <= coord_t'(cfg_data);
				default: ;
			endcase
		end
	end

	gne_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_data   (fq_data)
	);

	gne_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (bq_valid),
		.pop_ready  (bq_ready),
		.pop_data   (bq_data)
	);

	gne_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (bq_valid),
		.q_ready  (bq_ready),
		.q_data   (bq_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

FILE: sv/gne_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gne_front
// Input side: unpack a node transaction, drop the parent from the legal set
// and forward nodes with at least one successor to the queue.
// ----------------------------------------------------------------------------
module gne_front
	import gne_pkg::*;
(
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	// node_x, node_y, pred_x, pred_y, legal_mask
	input  wire logic [IN_W-1:0] s_tdata,
	// parent_valid
	input  wire logic            s_tuser,
	output logic                 q_valid,
	input  wire logic            q_ready,
	output node_t                q_data
);

	coord_t        nx, ny, px, py;
	logic [NB-1:0] mask;
	logic [NB-1:0] keep;
	coord_t        sx [NB];
	coord_t        sy [NB];

	assign nx   = s_tdata[0              +: COORD_BITS];
	assign ny   = s_tdata[COORD_BITS     +: COORD_BITS];
	assign px   = s_tdata[2 * COORD_BITS +: COORD_BITS];
	assign py   = s_tdata[3 * COORD_BITS +: COORD_BITS];
	assign mask = s_tdata[4 * COORD_BITS +: NB];

	always_comb begin
		for (int i = 0; i < NB; i++) begin
			sx[i]   = step_x(nx, NB_W'(i));
			sy[i]   = step_y(ny, NB_W'(i));
			keep[i] = mask[i] && !(s_tuser && sx[i] == px && sy[i] == py);
		end
	end

	assign s_tready    = q_ready;
	assign q_valid     = s_tvalid && (keep != '0);
	assign q_data.x    = nx;
	assign q_data.y    = ny;
	assign q_data.mask = keep;

endmodule
`default_nettype wire

FILE: sv/gne_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gne_queue
// Short first-in first-out queue of classified nodes between the input side
// and the successor generator.
// ----------------------------------------------------------------------------
module gne_queue
	import gne_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire node_t push_data,
	output logic       pop_valid,
	input  wire logic  pop_ready,
	output node_t      pop_data
);

	node_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push, pop;

	assign push_ready = count_q != QCNT_W'(QDEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

FILE: sv/gne_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gne_back
// Successor generator: walk a node's kept neighbours at one per cycle
// unless stalled, then find coordinates, cost, estimate, goal hit in stages.
// ----------------------------------------------------------------------------
module gne_back
	import gne_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             q_valid,
	output logic                  q_ready,
	input  wire node_t            q_data,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// succ_x, succ_y, step_cost, goal_estimate, reaches_goal
	output logic [OUT_W-1:0]      m_tdata,
	output logic                  m_tlast
);

	logic              en, issue;
	logic              busy_q;
	node_t             cur_q;
	logic [NB-1:0]     rem_q, rem_next;
	logic [NB_W-1:0]   idx;

	logic              v_s1, v_s2, v_s3, v_s4;
	coord_t            sx_s1, sy_s1, sx_s2, sy_s2, sx_s3, sy_s3, sx_s4, sy_s4;
	logic              diag_s1, diag_s2, diag_s3;
	logic              last_s1, last_s2, last_s3, last_s4;
	coord_t            dx_s2, dy_s2;
	logic              hit_s2, hit_s3, hit_s4;
	coord_t            lo_s3, span_s3;
	logic [COORD_BITS:0] sum_s3;
	logic [COST_W-1:0] cost_s4;
	logic [EST_W-1:0]  est_s4, est_next;
	logic [COORD_BITS+COST_W-1:0] prod;

	assign en       = !v_s4 || m_tready;
	assign rem_next = rem_q & (rem_q - 1'b1);
	assign issue    = en && busy_q;
	assign q_ready  = en && (!busy_q || rem_next == '0);

	always_comb begin
		idx = '0;
		for (int i = NB - 1; i >= 0; i--)
			if (rem_q[i]) idx = NB_W'(i);
	end

	always_comb begin
		prod = {{COST_W{1'b0}}, lo_s3} * {{COORD_BITS{1'b0}}, COST_DIAG};
		if (cfg.mode == MODE_OCTILE)
			est_next = EST_W'(prod) + EST_W'({span_s3, {FRAC_BITS{1'b0}}});
		else
			est_next = EST_W'({sum_s3, {FRAC_BITS{1'b0}}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
		end else if (en) begin
			if (q_ready && q_valid) begin
				busy_q <= 1'b1;
				rem_q  <= q_data.mask;
			end else if (issue) begin
				rem_q <= rem_next;
				if (rem_next == '0)
					busy_q <= 1'b0;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (q_ready && q_valid)
				cur_q <= q_data;
			sx_s1   <= step_x(cur_q.x, idx);
			sy_s1   <= step_y(cur_q.y, idx);
			diag_s1 <= idx >= NB_PP;
			last_s1 <= rem_next == '0;

			sx_s2   <= sx_s1;
			sy_s2   <= sy_s1;
			diag_s2 <= diag_s1;
			last_s2 <= last_s1;
			dx_s2   <= (sx_s1 >= cfg.goal_x) ? sx_s1 - cfg.goal_x : cfg.goal_x - sx_s1;
			dy_s2   <= (sy_s1 >= cfg.goal_y) ? sy_s1 - cfg.goal_y : cfg.goal_y - sy_s1;
			hit_s2  <= sx_s1 == cfg.goal_x && sy_s1 == cfg.goal_y;

			sx_s3   <= sx_s2;
			sy_s3   <= sy_s2;
			diag_s3 <= diag_s2;
			last_s3 <= last_s2;
			hit_s3  <= hit_s2;
			lo_s3   <= (dx_s2 < dy_s2) ? dx_s2 : dy_s2;
			span_s3 <= (dx_s2 < dy_s2) ? dy_s2 - dx_s2 : dx_s2 - dy_s2;
			sum_s3  <= {1'b0, dx_s2} + {1'b0, dy_s2};

			sx_s4   <= sx_s3;
			sy_s4   <= sy_s3;
			cost_s4 <= diag_s3 ? COST_DIAG : COST_STRAIGHT;
			est_s4  <= est_next;
			hit_s4  <= hit_s3;
			last_s4 <= last_s3;
		end
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = OUT_W'({hit_s4, est_s4, cost_s4, sy_s4, sx_s4});
	assign m_tlast  = last_s4;

	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q != '0)
		else $error("busy with no neighbour left");

	a_cost_legal: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (cost_s4 == COST_STRAIGHT || cost_s4 == COST_DIAG))
		else $error("step cost out of set");

	a_hit_zero_est: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && hit_s4) |-> est_s4 == '0)
		else $error("goal hit with nonzero estimate");

endmodule
`default_nettype wire

FILE: verif/gne_successor_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gne_successor_check
// Watches the node and successor channels of the grid neighbour expander.
// Every node transaction is expanded into the successors it must yield, and
// each successor transaction is compared field by field with the oldest of
// them. Register writes update a private copy of mode and goal.
// ----------------------------------------------------------------------------
module gne_successor_check
	import gne_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	// node_x, node_y, pred_x, pred_y, legal_mask
	input  wire logic [IN_W-1:0]      s_tdata,
	// parent_valid
	input  wire logic                 s_tuser,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	// succ_x, succ_y, step_cost, goal_estimate, reaches_goal, zero pad
	input  wire logic [OUT_W-1:0]     m_tdata,
	input  wire logic                 m_tlast,
	output int                        errors,
	output int                        outstanding,
	output int                        checked,
	output int                        goal_hits
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [COST_W-1:0] COST_ONE   = COST_W'(1 << FRAC_BITS);
	localparam logic [COST_W-1:0] COST_ROOT2 = COST_W'(362);
	localparam int                MAX_PRINTS = 20;

	typedef struct packed {
		logic [NB-1:0] mask;
		coord_t        py;
		coord_t        px;
		coord_t        ny;
		coord_t        nx;
	} node_word_t;

	typedef struct packed {
		logic [OUT_W-OUT_BITS-1:0] pad;
		logic                      hit;
		logic [EST_W-1:0]          est;
		logic [COST_W-1:0]         cost;
		coord_t                    y;
		coord_t                    x;
	} succ_word_t;

	typedef struct {
		succ_word_t word;
		logic       last;
	} successor_t;

	logic         mode_q   = MODE_MANHATTAN;
	coord_t       goal_x_q = '0;
	coord_t       goal_y_q = '0;
	successor_t   successor_q[$];

	task automatic report(string what);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("ERROR %0t ns: %s", $realtime, what);
	endtask

	task automatic compare_field(string name, logic [EST_W-1:0] got, logic [EST_W-1:0] want);
		if (got !== want)
			report($sformatf("%s got %0h, expected %0h", name, got, want));
	endtask

	function automatic logic [EST_W-1:0] goal_distance(coord_t sx, coord_t sy);
		int unsigned dx;
		int unsigned dy;
		int unsigned lo;
		int unsigned hi;
		int unsigned h;
		dx = (sx >= goal_x_q) ? sx - goal_x_q : goal_x_q - sx;
		dy = (sy >= goal_y_q) ? sy - goal_y_q : goal_y_q - sy;
		lo = (dx < dy) ? dx : dy;
		hi = (dx < dy) ? dy : dx;
		if (mode_q == MODE_MANHATTAN)
			h = (dx + dy) << FRAC_BITS;
		else
			h = lo * COST_ROOT2 + ((hi - lo) << FRAC_BITS);
		return EST_W'(h);
	endfunction

	function automatic void expand_node(node_word_t n, logic pv);
		successor_t s;
		coord_t     sx;
		coord_t     sy;
		int         first;
		first = successor_q.size();
		for (int k = 0; k < NB; k++) begin
			if (!n.mask[k])
				continue;
			sx = n.nx;
			sy = n.ny;
			case (NB_W'(k))
				NB_LEFT:  sx = n.nx - 1'b1;
				NB_UP:    sy = n.ny - 1'b1;
				NB_RIGHT: sx = n.nx + 1'b1;
				NB_DOWN:  sy = n.ny + 1'b1;
				NB_PP: begin
					sx = n.nx + 1'b1;
					sy = n.ny + 1'b1;
				end
				NB_PM: begin
					sx = n.nx + 1'b1;
					sy = n.ny - 1'b1;
				end
				NB_MP: begin
					sx = n.nx - 1'b1;
					sy = n.ny + 1'b1;
				end
				default: begin
					sx = n.nx - 1'b1;
					sy = n.ny - 1'b1;
				end
			endcase
			// drop the move back onto the parent
			if (pv && sx == n.px && sy == n.py)
				continue;
			s.word.pad  = '0;
			s.word.x    = sx;
			s.word.y    = sy;
			s.word.cost = (NB_W'(k) >= NB_PP) ? COST_ROOT2 : COST_ONE;
			s.word.est  = goal_distance(sx, sy);
			s.word.hit  = (sx == goal_x_q) && (sy == goal_y_q);
			s.last      = 1'b0;
			successor_q.push_back(s);
		end
		if (successor_q.size() > first)
			successor_q[successor_q.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk) begin : monitor
		succ_word_t got;
		successor_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HEURISTIC_MODE: mode_q   = cfg_data[0];
					REG_GOAL_X:         goal_x_q = cfg_data;
					REG_GOAL_Y:         goal_y_q = cfg_data;
					default: ;
				endcase
			end
			// successors leave before a node taken in the same cycle can add any
			if (m_tvalid && m_tready) begin
				got = succ_word_t'(m_tdata);
				if (successor_q.size() == 0) begin
					report($sformatf("successor (%0h,%0h) with nothing expected", got.x, got.y));
				end else begin
					want = successor_q.pop_front();
					compare_field("succ_x", got.x, want.word.x);
					compare_field("succ_y", got.y, want.word.y);
					compare_field("step_cost", got.cost, want.word.cost);
					compare_field("goal_estimate", got.est, want.word.est);
					compare_field("reaches_goal", got.hit, want.word.hit);
					compare_field("tlast", m_tlast, want.last);
					checked <= checked + 1;
					if (want.word.hit)
						goal_hits <= goal_hits + 1;
				end
			end
			if (s_tvalid && s_tready)
				expand_node(node_word_t'(s_tdata), s_tuser);
			outstanding <= successor_q.size();
		end
	end

endmodule
`default_nettype wire

FILE: verif/tb_grid_neighbour_expander.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_grid_neighbour_expander
// Drives node transactions and register writes into the grid neighbour
// expander and stalls its successor output at random; a checker beside the
// block predicts and compares every successor. Directed nodes cover empty
// and full masks, wrapping at both grid edges, parent exclusion and goal
// hits, followed by random searches under several mode and goal settings.
// ----------------------------------------------------------------------------
module tb_grid_neighbour_expander;
	import gne_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 8;
	localparam int NODES_PER_PHASE = 49;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = REG_HEURISTIC_MODE;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata   = '0;
	logic                 s_tuser   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 m_tlast;

	int     errors;
	int     outstanding;
	int     checked;
	int     goal_hits;
	int     nodes_sent = 0;
	int     searches   = 0;
	int     idle_cycles = 0;
	bit     burst      = 1'b0;
	bit     hold_req   = 1'b0;
	coord_t cur_gx     = '0;
	coord_t cur_gy     = '0;

	grid_neighbour_expander u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	gne_successor_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked),
		.goal_hits   (goal_hits)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// successor side: random stalls, and one long hold-off on request
	initial begin : receiver
		int w;
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			w = burst ? 0 : $urandom_range(0, 6);
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
		end
	end

	task automatic send_node(coord_t nx, coord_t ny, logic pv, coord_t px, coord_t py,
			logic [NB-1:0] mask);
		int gap;
		s_tdata  <= {mask, py, px, ny, nx};
		s_tuser  <= pv;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		nodes_sent++;
		gap = burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold the node side until every successor is out and the block is quiet
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_search(logic mode, coord_t gx, coord_t gy);
		logic [CFG_W-1:0] word;
		word    = CFG_W'($urandom());
		word[0] = mode;
		cfg_we    <= 1'b1;
		cfg_index <= REG_HEURISTIC_MODE;
		cfg_data  <= word;
		@(posedge clk);
		cfg_index <= REG_GOAL_X;
		cfg_data  <= gx;
		@(posedge clk);
		cfg_index <= REG_GOAL_Y;
		cfg_data  <= gy;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_gx = gx;
		cur_gy = gy;
		searches++;
	endtask

	task automatic random_node(bit full);
		coord_t        nx;
		coord_t        ny;
		coord_t        px;
		coord_t        py;
		logic          pv;
		logic [NB-1:0] mask;
		int            pick;
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			nx = cur_gx + coord_t'($urandom_range(0, 4)) - coord_t'(2);
			ny = cur_gy + coord_t'($urandom_range(0, 4)) - coord_t'(2);
		end else if (pick < 5) begin
			nx = $urandom_range(0, 1) ? coord_t'($urandom_range(0, 1))
				: ~coord_t'($urandom_range(0, 1));
			ny = $urandom_range(0, 1) ? coord_t'($urandom_range(0, 1))
				: ~coord_t'($urandom_range(0, 1));
		end else begin
			nx = coord_t'($urandom());
			ny = coord_t'($urandom());
		end
		pv = ($urandom_range(0, 4) != 0);
		if ($urandom_range(0, 9) < 7) begin
			px = nx + coord_t'($urandom_range(0, 2)) - coord_t'(1);
			py = ny + coord_t'($urandom_range(0, 2)) - coord_t'(1);
		end else begin
			px = coord_t'($urandom());
			py = coord_t'($urandom());
		end
		case ($urandom_range(0, 7))
			0:       mask = '1;
			1:       mask = NB'(1) << $urandom_range(0, NB - 1);
			default: mask = NB'($urandom());
		endcase
		if (full)
			mask = '1;
		send_node(nx, ny, pv, px, py, mask);
	endtask

	initial begin : stimulus
		logic mode;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at their reset values: Manhattan, goal at the origin
		send_node(16'd5, 16'd5, 1'b0, 16'd0, 16'd0, 8'h00);
		send_node(16'd5, 16'd5, 1'b0, 16'd0, 16'd0, 8'hFF);
		send_node(16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 8'hFF);
		send_node(16'd1, 16'd1, 1'b0, 16'd0, 16'd0, 8'hFF);
		send_node(16'hFFFF, 16'hFFFF, 1'b0, 16'd0, 16'd0, 8'hFF);
		send_node(16'hFFFE, 16'hFFFE, 1'b0, 16'd0, 16'd0, 8'h10);
		for (int a = -1; a <= 1; a++)
			for (int b = -1; b <= 1; b++)
				send_node(16'd100, 16'd200, 1'b1, coord_t'(100 + a), coord_t'(200 + b),
					8'hFF);
		send_node(16'd100, 16'd200, 1'b1, 16'd500, 16'd500, 8'hFF);
		send_node(16'd100, 16'd200, 1'b0, 16'd99, 16'd200, 8'hFF);
		drain();

		set_search(MODE_OCTILE, 16'hFFFF, 16'hFFFF);
		send_node(16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 8'hFF);
		send_node(16'h8000, 16'd0, 1'b1, 16'h7FFF, 16'hFFFF, 8'hFF);
		send_node(16'hFFFF, 16'hFFFE, 1'b0, 16'd0, 16'd0, 8'h08);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			mode = p[0];
			case (p)
				0:       set_search(mode, 16'd0, 16'd0);
				1:       set_search(mode, 16'hFFFF, 16'hFFFF);
				2:       set_search(mode, 16'd0, 16'hFFFF);
				default: set_search(mode, coord_t'($urandom()), coord_t'($urandom()));
			endcase
			burst = (p == 5) || ($urandom_range(0, 4) == 0);
			if (p == 3)
				hold_req = 1'b1;
			for (int i = 0; i < NODES_PER_PHASE; i++)
				random_node(p == 3 && i < 12);
			drain();
		end

		$display("Covered %0d nodes and %0d successors (%0d goal hits) over %0d searches,",
			nodes_sent, checked, goal_hits, searches + 1);
		$display("both estimate modes, edge wrapping and a %0d-cycle output hold-off.",
			HOLD_CYCLES);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

FILE: grid_neighbour_expander.f
sv/gne_pkg.sv
sv/gne_front.sv
sv/gne_queue.sv
sv/gne_back.sv
sv/grid_neighbour_expander.sv
verif/gne_successor_check.sv
verif/tb_grid_neighbour_expander.sv
